### rtl/core/rwfs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rwfs_pkg
// Shared types and fixed widths for the range weighted frequency square sum
// block.
// ----------------------------------------------------------------------------
package rwfs_pkg;

    localparam int POS_W = 12;  // array position, as carried by the query fields
    localparam int END_W = 13;  // exclusive window end, reaches 4096
    localparam int LEN_W = 13;  // array length register
    localparam int CNT_W = 13;  // per-value count, at most 4096
    localparam int SUM_W = 36;  // running sum, kept modulo 2^36

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef struct packed {
        logic             op;
        logic [11:0]      load_index;
        logic [11:0]      load_value;
        logic [11:0]      query_left;
        logic [11:0]      query_right;
    } item_t;

    typedef struct packed {
        logic [SUM_W-1:0] array_power;
        logic             query_error;
    } result_t;

    // Control handed from the sequencer to the sum datapath.
    typedef struct packed {
        logic fire;
        logic remove;
    } upd_ctrl_t;

endpackage

### rtl/core/rwfs_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rwfs_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read.
// ----------------------------------------------------------------------------
module rwfs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

### rtl/core/rwfs_accum.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rwfs_accum
// Running sum datapath: forms the weight change of one window move,
// registers it, then adds it to, or takes it from, the running sum.
// ----------------------------------------------------------------------------
module rwfs_accum
    import rwfs_pkg::*;
#(
    parameter int VALUE_BITS = 12
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  upd_ctrl_t             ctrl,
    input  logic [CNT_W-1:0]      prior,
    input  logic [VALUE_BITS-1:0] value,
    output logic [SUM_W-1:0]      sum
);

    localparam int COEF_W = CNT_W + 1;
    localparam int PROD_W = COEF_W + VALUE_BITS;

    logic [COEF_W-1:0] coef;
    logic              skip;
    logic [PROD_W-1:0] prod_reg, prod_next;
    logic              pend_reg, pend_next;
    logic              sub_reg, sub_next;
    logic [SUM_W-1:0]  sum_reg, sum_next;

    // Inserting at count p adds (2p+1)v; removing at count p takes (2p-1)v.
    always_comb
    begin
        skip = ctrl.remove && (prior == '0);
        if (ctrl.remove)
        begin
            coef = {prior, 1'b0} - COEF_W'(1);
        end
        else
        begin
            coef = {prior, 1'b0} + COEF_W'(1);
        end
        prod_next = PROD_W'(coef) * PROD_W'(value);
        pend_next = ctrl.fire && !skip;
        sub_next  = ctrl.remove;
        sum_next  = sum_reg;
        if (pend_reg)
        begin
            if (sub_reg)
            begin
                sum_next = sum_reg - SUM_W'(prod_reg);
            end
            else
            begin
                sum_next = sum_reg + SUM_W'(prod_reg);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= 1'b0;
            sum_reg  <= '0;
        end
        else
        begin
            pend_reg <= pend_next;
            sum_reg  <= sum_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        sub_reg  <= sub_next;
    end

    assign sum = sum_reg;

endmodule

### rtl/core/range_weighted_freq_square_sum.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// range_weighted_freq_square_sum
// Loads an element array, then answers inclusive range queries with the sum
// of count squared times value, using a sliding window over the array.
// ----------------------------------------------------------------------------
// After reset the block clears all 2^VALUE_BITS entries of its count table
// and accepts no item during that time. A load is written into the element
// store as it is transferred. A query moves the window ends one element at
// a time from the previous window to the new range; each move is an element
// store read, a count table read and a count write-back, done one after the
// other through the two RAMs. An invalid query makes no moves and goes
// straight to its result. One item is worked on at a time; a finished result
// sits in an output register while the next item is taken.
// ----------------------------------------------------------------------------
module range_weighted_freq_square_sum
    import rwfs_pkg::*;
#(
    parameter int ARRAY_DEPTH = 4096,
    parameter int VALUE_BITS  = 12
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_wr_en,
    input  logic [LEN_W-1:0] cfg_wr_data,
    input  logic             item_valid,
    output logic             item_ready,
    input  item_t            item,
    output logic             result_valid,
    input  logic             result_ready,
    output result_t          result
);

    localparam int AW     = (ARRAY_DEPTH > 1) ? $clog2(ARRAY_DEPTH) : 1;
    localparam int VDEPTH = 1 << VALUE_BITS;

    localparam logic [2:0] S_CLR  = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_MOVE = 3'd2;
    localparam logic [2:0] S_CNT  = 3'd3;
    localparam logic [2:0] S_UPD  = 3'd4;
    localparam logic [2:0] S_FIN  = 3'd5;

    logic [2:0]            state_reg, state_next;
    logic                  closed_reg, closed_next;
    logic [LEN_W-1:0]      len_reg, len_next;
    logic [POS_W-1:0]      ws_reg, ws_next;
    logic [END_W-1:0]      we_reg, we_next;
    logic [POS_W-1:0]      left_reg, left_next;
    logic [POS_W-1:0]      right_reg, right_next;
    logic                  err_reg, err_next;
    logic                  rm_reg, rm_next;
    logic [VALUE_BITS-1:0] val_reg, val_next;
    logic [VALUE_BITS-1:0] clr_reg, clr_next;
    logic                  res_valid_reg, res_valid_next;
    result_t               res_reg, res_next;

    logic                  accept;
    logic                  bad_range;
    logic [END_W-1:0]      right_ext;
    logic [END_W-1:0]      we_dec;
    logic [POS_W-1:0]      move_pos;

    logic                  elem_wr_en;
    logic                  elem_rd_en;
    logic [VALUE_BITS-1:0] elem_rd_data;
    logic                  cnt_wr_en;
    logic [VALUE_BITS-1:0] cnt_wr_addr;
    logic [CNT_W-1:0]      cnt_wr_data;
    logic                  cnt_rd_en;
    logic [CNT_W-1:0]      cnt_rd_data;
    upd_ctrl_t             upd_ctrl;
    logic [SUM_W-1:0]      sum;

    assign item_ready = (state_reg == S_IDLE);
    assign accept     = item_valid && item_ready;
    assign right_ext  = {1'b0, item.query_right};
    assign bad_range  = (item.query_left > item.query_right) || (right_ext >= len_reg)
                        || (32'(item.query_right) >= 32'(ARRAY_DEPTH));
    assign we_dec     = we_reg - END_W'(1);
    assign elem_wr_en = accept && (item.op == OP_LOAD) && !closed_reg
                        && (32'(item.load_index) < 32'(ARRAY_DEPTH));

    always_comb
    begin
        state_next     = state_reg;
        closed_next    = closed_reg;
        len_next       = cfg_wr_en ? cfg_wr_data : len_reg;
        ws_next        = ws_reg;
        we_next        = we_reg;
        left_next      = left_reg;
        right_next     = right_reg;
        err_next       = err_reg;
        rm_next        = rm_reg;
        val_next       = val_reg;
        clr_next       = clr_reg;
        res_valid_next = res_valid_reg && !result_ready;
        res_next       = res_reg;
        move_pos       = ws_reg;
        elem_rd_en     = 1'b0;
        cnt_wr_en      = 1'b0;
        cnt_wr_addr    = val_reg;
        cnt_wr_data    = cnt_rd_data;
        cnt_rd_en      = 1'b0;
        upd_ctrl       = '0;

        unique case (state_reg)
            S_CLR:
            begin
                cnt_wr_en   = 1'b1;
                cnt_wr_addr = clr_reg;
                cnt_wr_data = '0;
                clr_next    = clr_reg + VALUE_BITS'(1);
                if (clr_reg == '1)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept && (item.op == OP_QUERY))
                begin
                    closed_next = 1'b1;
                    left_next   = item.query_left;
                    right_next  = item.query_right;
                    err_next    = bad_range;
                    state_next  = bad_range ? S_FIN : S_MOVE;
                end
            end
            S_MOVE:
            begin
                // Grow on the right, grow on the left, then shrink right and left.
                state_next = S_CNT;
                elem_rd_en = 1'b1;
                if (we_reg <= {1'b0, right_reg})
                begin
                    move_pos = we_reg[POS_W-1:0];
                    we_next  = we_reg + END_W'(1);
                    rm_next  = 1'b0;
                end
                else if (ws_reg > left_reg)
                begin
                    move_pos = ws_reg - POS_W'(1);
                    ws_next  = ws_reg - POS_W'(1);
                    rm_next  = 1'b0;
                end
                else if (we_reg > ({1'b0, right_reg} + END_W'(1)))
                begin
                    move_pos = we_dec[POS_W-1:0];
                    we_next  = we_dec;
                    rm_next  = 1'b1;
                end
                else if (ws_reg < left_reg)
                begin
                    move_pos = ws_reg;
                    ws_next  = ws_reg + POS_W'(1);
                    rm_next  = 1'b1;
                end
                else
                begin
                    elem_rd_en = 1'b0;
                    state_next = S_FIN;
                end
            end
            S_CNT:
            begin
                cnt_rd_en  = 1'b1;
                val_next   = elem_rd_data;
                state_next = S_UPD;
            end
            S_UPD:
            begin
                // Counts are written back here, before the next move reads the count
                // table, so the next move always sees the new value.
                upd_ctrl.fire   = 1'b1;
                upd_ctrl.remove = rm_reg;
                cnt_wr_en       = 1'b1;
                if (!rm_reg)
                begin
                    cnt_wr_data = cnt_rd_data + CNT_W'(1);
                end
                else if (cnt_rd_data != '0)
                begin
                    cnt_wr_data = cnt_rd_data - CNT_W'(1);
                end
                state_next = S_MOVE;
            end
            S_FIN:
            begin
                if (!res_valid_reg || result_ready)
                begin
                    res_valid_next        = 1'b1;
                    res_next.query_error  = err_reg;
                    res_next.array_power  = err_reg ? '0 : sum;
                    state_next            = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLR;
            closed_reg    <= 1'b0;
            len_reg       <= LEN_W'(1);
            ws_reg        <= '0;
            we_reg        <= '0;
            clr_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            closed_reg    <= closed_next;
            len_reg       <= len_next;
            ws_reg        <= ws_next;
            we_reg        <= we_next;
            clr_reg       <= clr_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        left_reg  <= left_next;
        right_reg <= right_next;
        err_reg   <= err_next;
        rm_reg    <= rm_next;
        val_reg   <= val_next;
        res_reg   <= res_next;
    end

    rwfs_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (ARRAY_DEPTH)
    ) u_elem_ram (
        .clk     (clk),
        .wr_en   (elem_wr_en),
        .wr_addr (AW'(item.load_index)),
        .wr_data (VALUE_BITS'(item.load_value)),
        .rd_en   (elem_rd_en),
        .rd_addr (AW'(move_pos)),
        .rd_data (elem_rd_data)
    );

    rwfs_ram #(
        .WIDTH (CNT_W),
        .DEPTH (VDEPTH)
    ) u_cnt_ram (
        .clk     (clk),
        .wr_en   (cnt_wr_en),
        .wr_addr (cnt_wr_addr),
        .wr_data (cnt_wr_data),
        .rd_en   (cnt_rd_en),
        .rd_addr (elem_rd_data),
        .rd_data (cnt_rd_data)
    );

    rwfs_accum #(
        .VALUE_BITS (VALUE_BITS)
    ) u_accum (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (upd_ctrl),
        .prior (cnt_rd_data),
        .value (val_reg),
        .sum   (sum)
    );

    assign result_valid = res_valid_reg;
    assign result       = res_reg;

endmodule

### rtl/core/rwfs_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rwfs_checker
// Port-level checks for the range weighted frequency square sum block,
// bound to the top level.
// ----------------------------------------------------------------------------
module rwfs_checker
    import rwfs_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    item_valid,
    input logic    item_ready,
    input item_t   item,
    input logic    result_valid,
    input logic    result_ready,
    input result_t result
);

    // A result that is not taken stays put.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
        else $error("result changed or dropped while stalled");

    // A flagged range never reports a sum.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.query_error |-> result.array_power == '0)
        else $error("error result carries a non-zero sum");

    // A load transfer never produces a result.
    assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready && (item.op == OP_LOAD) |=> !$rose(result_valid))
        else $error("result appeared after a load");

    // A query keeps the block busy for at least the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready && (item.op == OP_QUERY) |=> !item_ready)
        else $error("item taken directly after a query");

endmodule

bind range_weighted_freq_square_sum rwfs_checker u_rwfs_checker (.*);
